// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check, sampled on clk, off while reset is asserted.
`define CHK_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle check.
`define CHK_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
`default_nettype none

package i2cm_pkg;

	localparam int BYTE_BITS = 8;

	typedef enum logic [2:0] {
		CMD_IDLE     = 3'd0,
		CMD_START    = 3'd1,
		CMD_STOP     = 3'd2,
		CMD_WRITE    = 3'd3,
		CMD_WAITACK  = 3'd4,
		CMD_READ     = 3'd5,
		CMD_FAILSTOP = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		REG_COND_PHASE  = 3'd0,
		REG_ACK_PHASE   = 3'd1,
		REG_BIT_PHASE   = 3'd2,
		REG_READ_HOLD   = 3'd3,
		REG_ACK_TIMEOUT = 3'd4
	} reg_idx_t;

	localparam logic [3:0] STEP_END = 4'd15;

	localparam logic [7:0] RST_COND_PHASE  = 8'd4;
	localparam logic [7:0] RST_ACK_PHASE   = 8'd6;
	localparam logic [7:0] RST_BIT_PHASE   = 8'd10;
	localparam logic [7:0] RST_READ_HOLD   = 8'd5;
	localparam logic [7:0] RST_ACK_TIMEOUT = 8'd250;

	localparam int ADDR_W = 5;

	typedef struct packed {
		logic [7:0] cond_phase_us;
		logic [7:0] ack_phase_us;
		logic [7:0] bit_phase_us;
		logic [7:0] read_hold_us;
		logic [7:0] ack_timeout_polls;
	} cfg_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] write_data;
		logic       send_ack;
		logic       sda_sample;
	} item_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [3:0] step;
		logic [7:0] ticks;
		logic [3:0] bit_cnt;
		logic [7:0] shift;
		logic [7:0] poll;
		logic       ack_choice;
		logic       scl;
		logic       sda;
		logic       drv;
		logic [7:0] last_read;
	} eng_state_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_failed;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/i2c_master_bit_engine.sv =====
// channel   direction  handshake           payload
// in        request    in_valid/in_stall   action, write_data, send_ack, sda_sample
// out       result     out_valid/out_stall scl_level, sda_level, sda_drive, busy_res,
//                                          done_res, read_data, ack_failed
// cfg       APB write  psel/penable/pready paddr, pwdata, prdata
//
// One request per cycle sustained while out_stall does not hold the result; the bus state
// updates from the registered request and is presented through the result register.
// Reset loads the default phase settings, idles the engine and sets its SCL/SDA state high.
// out_stall holds the result register; the request register then fills and in_stall rises.
`default_nettype none

module i2c_master_bit_engine (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [2:0]                  action,
	input  wire logic [7:0]                  write_data,
	input  wire logic                        send_ack,
	input  wire logic                        sda_sample,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             scl_level,
	output logic                             sda_level,
	output logic                             sda_drive,
	output logic                             busy_res,
	output logic                             done_res,
	output logic [7:0]                       read_data,
	output logic                             ack_failed,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [i2cm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);
	import i2cm_pkg::*;

	cfg_t       cfg;
	item_t      item_s1;
	logic       valid_s1;
	eng_state_t state_q;
	eng_state_t state_nxt;
	res_t       res_nxt;
	res_t       res_q;
	logic       out_valid_q;
	logic       adv;
	logic       accept;

	i2cm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	i2cm_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action     <= action;
			item_s1.write_data <= write_data;
			item_s1.send_ack   <= send_ack;
			item_s1.sda_sample <= sda_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cmd        <= CMD_IDLE;
			state_q.step       <= 4'd0;
			state_q.ticks      <= 8'd0;
			state_q.bit_cnt    <= 4'd0;
			state_q.shift      <= 8'd0;
			state_q.poll       <= 8'd0;
			state_q.ack_choice <= 1'b0;
			state_q.scl        <= 1'b1;
			state_q.sda        <= 1'b1;
			state_q.drv        <= 1'b1;
			state_q.last_read  <= 8'd0;
			out_valid_q        <= 1'b0;
		end else begin
			if (adv) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign scl_level  = res_q.scl_level;
	assign sda_level  = res_q.sda_level;
	assign sda_drive  = res_q.sda_drive;
	assign busy_res   = res_q.busy_res;
	assign done_res   = res_q.done_res;
	assign read_data  = res_q.read_data;
	assign ack_failed = res_q.ack_failed;

endmodule

`default_nettype wire

// ===== rtl/i2cm_regs.sv =====
`default_nettype none

module i2cm_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [i2cm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output i2cm_pkg::cfg_t                   cfg
);
	import i2cm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cond_phase_us     <= RST_COND_PHASE;
			cfg_q.ack_phase_us      <= RST_ACK_PHASE;
			cfg_q.bit_phase_us      <= RST_BIT_PHASE;
			cfg_q.read_hold_us      <= RST_READ_HOLD;
			cfg_q.ack_timeout_polls <= RST_ACK_TIMEOUT;
		end else if (wr_en) begin
			case (idx)
				REG_COND_PHASE:  cfg_q.cond_phase_us     <= pwdata[7:0];
				REG_ACK_PHASE:   cfg_q.ack_phase_us      <= pwdata[7:0];
				REG_BIT_PHASE:   cfg_q.bit_phase_us      <= pwdata[7:0];
				REG_READ_HOLD:   cfg_q.read_hold_us      <= pwdata[7:0];
				REG_ACK_TIMEOUT: cfg_q.ack_timeout_polls <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_COND_PHASE:  prdata = {24'd0, cfg_q.cond_phase_us};
			REG_ACK_PHASE:   prdata = {24'd0, cfg_q.ack_phase_us};
			REG_BIT_PHASE:   prdata = {24'd0, cfg_q.bit_phase_us};
			REG_READ_HOLD:   prdata = {24'd0, cfg_q.read_hold_us};
			REG_ACK_TIMEOUT: prdata = {24'd0, cfg_q.ack_timeout_polls};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/i2cm_step.sv =====
`default_nettype none

module i2cm_step (
	input  i2cm_pkg::cfg_t       cfg,
	input  i2cm_pkg::eng_state_t cur,
	input  i2cm_pkg::item_t      item,
	output i2cm_pkg::eng_state_t nxt,
	output i2cm_pkg::res_t       res
);
	import i2cm_pkg::*;

	function automatic logic [7:0] dur(input logic [7:0] r);
		dur = (r == 8'd0) ? 8'd1 : r;
	endfunction

	always_comb begin
		eng_state_t n;
		logic       enter;
		logic       fin;
		logic [3:0] nx;
		logic [3:0] bc;
		logic [7:0] d;

		n     = cur;
		enter = 1'b0;
		fin   = 1'b0;
		nx    = STEP_END;
		bc    = cur.bit_cnt + 4'd1;
		d     = 8'd1;

		if (cur.cmd == CMD_IDLE) begin
			if (item.action inside {[CMD_START:CMD_READ]}) begin
				n.cmd        = cmd_t'(item.action);
				n.step       = 4'd0;
				n.bit_cnt    = 4'd0;
				n.poll       = 8'd0;
				n.shift      = (item.action == CMD_WRITE) ? item.write_data : 8'd0;
				n.ack_choice = item.send_ack;
				enter        = 1'b1;
			end
		end else if (cur.cmd == CMD_WAITACK && cur.step == 4'd2) begin
			if (!item.sda_sample) begin
				n.scl = 1'b0;
				fin   = 1'b1;
			end else if (cur.poll >= cfg.ack_timeout_polls) begin
				n.cmd  = CMD_FAILSTOP;
				n.step = 4'd0;
				enter  = 1'b1;
			end else begin
				n.poll = cur.poll + 8'd1;
			end
		end else begin
			n.ticks = cur.ticks - 8'd1;
			if (n.ticks == 8'd0) begin
				case (cur.cmd)
					CMD_START, CMD_STOP, CMD_FAILSTOP: begin
						nx = (cur.step >= 4'd3) ? STEP_END : cur.step + 4'd1;
					end
					CMD_WRITE: begin
						if (cur.step < 4'd2) begin
							nx = cur.step + 4'd1;
						end else begin
							n.bit_cnt = bc;
							nx = (bc >= 4'(BYTE_BITS)) ? STEP_END : 4'd0;
						end
					end
					CMD_WAITACK: nx = cur.step + 4'd1;
					CMD_READ: begin
						if (cur.step == 4'd0 || cur.step == 4'd2) begin
							nx = cur.step + 4'd1;
						end else if (cur.step == 4'd1) begin
							n.bit_cnt = bc;
							nx = (bc >= 4'(BYTE_BITS)) ? 4'd2 : 4'd0;
						end else begin
							nx = STEP_END;
						end
					end
					default: nx = STEP_END;
				endcase
				if (nx == STEP_END) begin
					fin = 1'b1;
				end else begin
					n.step = nx;
					enter  = 1'b1;
				end
			end
		end

		// phase entry: line levels and phase length
		if (enter) begin
			case (n.cmd)
				CMD_START: begin
					d = dur(cfg.cond_phase_us);
					case (n.step)
						4'd0: begin n.drv = 1'b1; n.sda = 1'b1; end
						4'd1: n.scl = 1'b1;
						4'd2: n.sda = 1'b0;
						default: n.scl = 1'b0;
					endcase
				end
				CMD_STOP, CMD_FAILSTOP: begin
					d = dur(cfg.cond_phase_us);
					case (n.step)
						4'd0: begin n.drv = 1'b1; n.scl = 1'b0; end
						4'd1: n.sda = 1'b0;
						4'd2: n.scl = 1'b1;
						default: n.sda = 1'b1;
					endcase
				end
				CMD_WRITE: begin
					d = dur(cfg.bit_phase_us);
					case (n.step)
						4'd0: begin
							n.drv   = 1'b1;
							n.scl   = 1'b0;
							n.sda   = n.shift[7];
							n.shift = {n.shift[6:0], 1'b0};
						end
						4'd1: n.scl = 1'b1;
						default: n.scl = 1'b0;
					endcase
				end
				CMD_WAITACK: begin
					d = dur(cfg.ack_phase_us);
					case (n.step)
						4'd0: begin n.drv = 1'b0; n.sda = 1'b1; end
						4'd1: n.scl = 1'b1;
						default: n.poll = 8'd0;
					endcase
				end
				CMD_READ: begin
					case (n.step)
						4'd0: begin
							d     = dur(cfg.bit_phase_us);
							n.drv = 1'b0;
							n.sda = 1'b1;
							n.scl = 1'b0;
						end
						4'd1: begin
							d       = dur(cfg.read_hold_us);
							n.scl   = 1'b1;
							n.shift = {n.shift[6:0], item.sda_sample};
						end
						4'd2: begin
							d     = dur(cfg.bit_phase_us);
							n.scl = 1'b0;
							n.drv = 1'b1;
							n.sda = ~n.ack_choice;
						end
						default: begin
							d     = dur(cfg.bit_phase_us);
							n.scl = 1'b1;
						end
					endcase
				end
				default: d = 8'd1;
			endcase
			n.ticks = d;
		end

		res.done_res   = fin;
		res.ack_failed = fin && (n.cmd == CMD_FAILSTOP);
		if (fin) begin
			if (n.cmd == CMD_READ) begin
				n.scl       = 1'b0;
				n.last_read = n.shift;
			end
			n.cmd  = CMD_IDLE;
			n.step = 4'd0;
		end

		res.scl_level = n.scl;
		res.sda_level = n.sda;
		res.sda_drive = n.drv;
		res.busy_res  = (n.cmd != CMD_IDLE);
		res.read_data = n.last_read;
		nxt           = n;
	end

endmodule

`default_nettype wire

// ===== rtl/i2cm_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module i2cm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       scl_level,
	input wire logic       sda_level,
	input wire logic       sda_drive,
	input wire logic       busy_res,
	input wire logic       done_res,
	input wire logic [7:0] read_data,
	input wire logic       ack_failed
);

	`CHK_NOW(a_done_idle, out_valid && done_res, !busy_res, "done with busy still set")
	`CHK_NOW(a_fail_done, out_valid && ack_failed, done_res, "ack failure without done")
	`CHK_NOW(a_fail_stop, out_valid && ack_failed, scl_level && sda_level && sda_drive, "no stop")
	`CHK_NOW(a_release, out_valid && !sda_drive, sda_level, "released SDA must read high")
	`CHK_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(read_data), "stalled result changed")

endmodule

bind i2c_master_bit_engine i2cm_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.scl_level  (scl_level),
	.sda_level  (sda_level),
	.sda_drive  (sda_drive),
	.busy_res   (busy_res),
	.done_res   (done_res),
	.read_data  (read_data),
	.ack_failed (ack_failed)
);

`default_nettype wire

// ===== tb/tb_i2c_master_bit_engine.sv =====
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine;
	import i2cm_pkg::*;

	localparam int SDA_LOW    = 0;
	localparam int SDA_HIGH   = 1;
	localparam int SDA_RANDOM = 2;
	localparam int NO_ACK     = -1;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        action;
	logic [7:0]        write_data;
	logic              send_ack;
	logic              sda_sample;
	logic              out_valid;
	logic              out_stall;
	logic              scl_level;
	logic              sda_level;
	logic              sda_drive;
	logic              busy_res;
	logic              done_res;
	logic [7:0]        read_data;
	logic              ack_failed;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	i2c_master_bit_engine dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.write_data (write_data),
		.send_ack   (send_ack),
		.sda_sample (sda_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.scl_level  (scl_level),
		.sda_level  (sda_level),
		.sda_drive  (sda_drive),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_data  (read_data),
		.ack_failed (ack_failed),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// bus engine mirror
	cfg_t       bus_cfg;
	cmd_t       bus_cmd;
	logic [3:0] bus_step;
	logic [7:0] bus_ticks;
	logic [3:0] bus_bits;
	logic [7:0] bus_shift;
	logic [7:0] bus_polls;
	logic       bus_ack;
	logic       line_scl;
	logic       line_sda;
	logic       line_drv;
	logic [7:0] bus_last_read;

	res_t bus_expect_q[$];
	int   fail_count;
	int   hold_req;
	bit   gaps_on;
	cmd_t last_issued;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [7:0] at_least_one(input logic [7:0] r);
		return (r == 8'd0) ? 8'd1 : r;
	endfunction

	task automatic reset_bus_model();
		bus_cfg.cond_phase_us     = RST_COND_PHASE;
		bus_cfg.ack_phase_us      = RST_ACK_PHASE;
		bus_cfg.bit_phase_us      = RST_BIT_PHASE;
		bus_cfg.read_hold_us      = RST_READ_HOLD;
		bus_cfg.ack_timeout_polls = RST_ACK_TIMEOUT;
		bus_cmd = CMD_IDLE;
		bus_step = 4'd0;
		bus_ticks = 8'd0;
		bus_bits = 4'd0;
		bus_shift = 8'd0;
		bus_polls = 8'd0;
		bus_ack = 1'b0;
		line_scl = 1'b1;
		line_sda = 1'b1;
		line_drv = 1'b1;
		bus_last_read = 8'd0;
	endtask

	task automatic load_phase(input logic sda_in);
		logic [7:0] d;
		d = 8'd1;
		case (bus_cmd)
			CMD_START: begin
				d = at_least_one(bus_cfg.cond_phase_us);
				case (bus_step)
					4'd0: begin line_drv = 1'b1; line_sda = 1'b1; end
					4'd1: line_scl = 1'b1;
					4'd2: line_sda = 1'b0;
					default: line_scl = 1'b0;
				endcase
			end
			CMD_STOP, CMD_FAILSTOP: begin
				d = at_least_one(bus_cfg.cond_phase_us);
				case (bus_step)
					4'd0: begin line_drv = 1'b1; line_scl = 1'b0; end
					4'd1: line_sda = 1'b0;
					4'd2: line_scl = 1'b1;
					default: line_sda = 1'b1;
				endcase
			end
			CMD_WRITE: begin
				d = at_least_one(bus_cfg.bit_phase_us);
				case (bus_step)
					4'd0: begin
						line_drv = 1'b1;
						line_scl = 1'b0;
						line_sda = bus_shift[7];
						bus_shift = bus_shift << 1;
					end
					4'd1: line_scl = 1'b1;
					default: line_scl = 1'b0;
				endcase
			end
			CMD_WAITACK: begin
				d = at_least_one(bus_cfg.ack_phase_us);
				case (bus_step)
					4'd0: begin line_drv = 1'b0; line_sda = 1'b1; end
					4'd1: line_scl = 1'b1;
					default: bus_polls = 8'd0;
				endcase
			end
			CMD_READ: begin
				case (bus_step)
					4'd0: begin
						d = at_least_one(bus_cfg.bit_phase_us);
						line_drv = 1'b0;
						line_sda = 1'b1;
						line_scl = 1'b0;
					end
					4'd1: begin
						d = at_least_one(bus_cfg.read_hold_us);
						line_scl = 1'b1;
						bus_shift = {bus_shift[6:0], sda_in};
					end
					4'd2: begin
						d = at_least_one(bus_cfg.bit_phase_us);
						line_scl = 1'b0;
						line_drv = 1'b1;
						line_sda = ~bus_ack;
					end
					default: begin
						d = at_least_one(bus_cfg.bit_phase_us);
						line_scl = 1'b1;
					end
				endcase
			end
			default: ;
		endcase
		bus_ticks = d;
	endtask

	task automatic next_phase(output logic [3:0] nx);
		case (bus_cmd)
			CMD_START, CMD_STOP, CMD_FAILSTOP:
				nx = (bus_step >= 4'd3) ? STEP_END : bus_step + 4'd1;
			CMD_WRITE: begin
				if (bus_step < 4'd2) begin
					nx = bus_step + 4'd1;
				end else begin
					bus_bits = bus_bits + 4'd1;
					nx = (bus_bits >= BYTE_BITS) ? STEP_END : 4'd0;
				end
			end
			CMD_WAITACK:
				nx = bus_step + 4'd1;
			CMD_READ: begin
				if (bus_step == 4'd0 || bus_step == 4'd2) begin
					nx = bus_step + 4'd1;
				end else if (bus_step == 4'd1) begin
					bus_bits = bus_bits + 4'd1;
					nx = (bus_bits >= BYTE_BITS) ? 4'd2 : 4'd0;
				end else begin
					nx = STEP_END;
				end
			end
			default:
				nx = STEP_END;
		endcase
	endtask

	// one microsecond tick of the bus engine
	task automatic advance_bus(input item_t it, output res_t r);
		logic       fin;
		logic       failed;
		logic [3:0] nx;
		fin = 1'b0;
		failed = 1'b0;
		if (bus_cmd == CMD_IDLE) begin
			if (it.action >= CMD_START && it.action <= CMD_READ) begin
				bus_cmd = cmd_t'(it.action);
				bus_step = 4'd0;
				bus_bits = 4'd0;
				bus_polls = 8'd0;
				bus_shift = (it.action == CMD_WRITE) ? it.write_data : 8'd0;
				bus_ack = it.send_ack;
				load_phase(it.sda_sample);
			end
		end else if (bus_cmd == CMD_WAITACK && bus_step == 4'd2) begin
			if (!it.sda_sample) begin
				line_scl = 1'b0;
				fin = 1'b1;
			end else if (bus_polls >= bus_cfg.ack_timeout_polls) begin
				bus_cmd = CMD_FAILSTOP;
				bus_step = 4'd0;
				load_phase(it.sda_sample);
			end else begin
				bus_polls = bus_polls + 8'd1;
			end
		end else begin
			bus_ticks = bus_ticks - 8'd1;
			if (bus_ticks == 8'd0) begin
				next_phase(nx);
				if (nx == STEP_END) begin
					fin = 1'b1;
				end else begin
					bus_step = nx;
					load_phase(it.sda_sample);
				end
			end
		end
		if (fin) begin
			if (bus_cmd == CMD_FAILSTOP)
				failed = 1'b1;
			if (bus_cmd == CMD_READ) begin
				line_scl = 1'b0;
				bus_last_read = bus_shift;
			end
			bus_cmd = CMD_IDLE;
			bus_step = 4'd0;
		end
		r.scl_level  = line_scl;
		r.sda_level  = line_sda;
		r.sda_drive  = line_drv;
		r.busy_res   = (bus_cmd != CMD_IDLE);
		r.done_res   = fin;
		r.read_data  = bus_last_read;
		r.ack_failed = failed;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	task automatic send_tick(input item_t it);
		res_t r;
		int   gap;
		in_valid   <= 1'b1;
		action     <= it.action;
		write_data <= it.write_data;
		send_ack   <= it.send_ack;
		sda_sample <= it.sda_sample;
		do @(posedge clk); while (in_stall);
		advance_bus(it, r);
		bus_expect_q.push_back(r);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (bus_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= {24'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_COND_PHASE:  bus_cfg.cond_phase_us = val;
			REG_ACK_PHASE:   bus_cfg.ack_phase_us = val;
			REG_BIT_PHASE:   bus_cfg.bit_phase_us = val;
			REG_READ_HOLD:   bus_cfg.read_hold_us = val;
			REG_ACK_TIMEOUT: bus_cfg.ack_timeout_polls = val;
			default: ;
		endcase
	endtask

	task automatic write_all_regs(input logic [7:0] cond, input logic [7:0] ackp,
			input logic [7:0] bitp, input logic [7:0] hold, input logic [7:0] tmo);
		write_reg(REG_COND_PHASE, cond);
		write_reg(REG_ACK_PHASE, ackp);
		write_reg(REG_BIT_PHASE, bitp);
		write_reg(REG_READ_HOLD, hold);
		write_reg(REG_ACK_TIMEOUT, tmo);
	endtask

	// issue one request, then tick until the engine is idle again
	task automatic run_command(input logic [2:0] act, input logic [7:0] data,
			input logic ack, input int ack_poll, input int sda_mode);
		item_t it;
		it.action     = act;
		it.write_data = data;
		it.send_ack   = ack;
		it.sda_sample = 1'($urandom());
		send_tick(it);
		while (bus_cmd != CMD_IDLE) begin
			it.action = ($urandom_range(0, 99) < 30) ? 3'($urandom_range(1, 7)) : CMD_IDLE;
			it.write_data = 8'($urandom());
			it.send_ack = 1'($urandom());
			if (bus_cmd == CMD_WAITACK && bus_step == 4'd2)
				it.sda_sample = !(ack_poll >= 0 && int'(bus_polls) >= ack_poll);
			else if (sda_mode == SDA_RANDOM)
				it.sda_sample = 1'($urandom());
			else
				it.sda_sample = (sda_mode == SDA_HIGH);
			send_tick(it);
		end
	endtask

	// mostly well-formed transactions, some noise
	task automatic make_tick(output item_t it);
		cmd_t nxt;
		int   r;
		it.write_data = 8'($urandom());
		it.send_ack = 1'($urandom());
		it.sda_sample = 1'($urandom());
		if (bus_cmd == CMD_WAITACK && bus_step == 4'd2)
			it.sda_sample = ($urandom_range(0, 99) >= 12);
		if (bus_cmd != CMD_IDLE) begin
			it.action = ($urandom_range(0, 99) < 20) ? 3'($urandom_range(1, 7)) : CMD_IDLE;
		end else if ($urandom_range(0, 99) < 15) begin
			it.action = 3'($urandom_range(0, 7));
		end else begin
			r = $urandom_range(0, 99);
			case (last_issued)
				CMD_START: nxt = CMD_WRITE;
				CMD_WRITE: nxt = CMD_WAITACK;
				CMD_WAITACK: nxt = (r < 40) ? CMD_WRITE : (r < 80) ? CMD_READ : CMD_STOP;
				CMD_READ: nxt = (r < 50) ? CMD_READ : CMD_STOP;
				default: nxt = CMD_START;
			endcase
			last_issued = nxt;
			it.action = nxt;
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (bus_expect_q.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = bus_expect_q.pop_front();
				check_field("scl_level", want.scl_level, scl_level);
				check_field("sda_level", want.sda_level, sda_level);
				check_field("sda_drive", want.sda_drive, sda_drive);
				check_field("busy_res", want.busy_res, busy_res);
				check_field("done_res", want.done_res, done_res);
				check_field("read_data", want.read_data, read_data);
				check_field("ack_failed", want.ack_failed, ack_failed);
			end
		end
	end

	// result side stalls; long holds on request
	initial begin
		int run_left;
		int hold_left;
		int r;
		run_left = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
				run_left = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					out_stall <= 1'b0;
					run_left = $urandom_range(0, 20);
				end else if (r < 62) begin
					out_stall <= 1'b0;
					run_left = $urandom_range(60, 150);
				end else if (r < 94) begin
					out_stall <= 1'b1;
					run_left = $urandom_range(0, 2);
				end else begin
					out_stall <= 1'b1;
					run_left = $urandom_range(8, 30);
				end
			end
		end
	end

	task automatic test_directed_commands();
		item_t it;
		int    i;
		for (i = 0; i < 4; i++) begin
			it.action = (i < 2) ? CMD_IDLE : 3'(CMD_FAILSTOP + i - 2);
			it.write_data = 8'($urandom());
			it.send_ack = 1'(i);
			it.sda_sample = 1'(i);
			send_tick(it);
		end
		run_command(CMD_START, 8'h00, 1'b0, 0, SDA_RANDOM);
		run_command(CMD_WAITACK, 8'h00, 1'b0, 0, SDA_RANDOM);
		run_command(CMD_READ, 8'h00, 1'b1, 0, SDA_HIGH);
		run_command(CMD_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);
		settle();
		write_all_regs(8'd1, 8'd1, 8'd2, 8'd1, 8'd3);
		run_command(CMD_START, 8'h00, 1'b0, 0, SDA_RANDOM);
		run_command(CMD_WRITE, 8'hFF, 1'b0, 0, SDA_RANDOM);
		run_command(CMD_WAITACK, 8'h00, 1'b0, 0, SDA_RANDOM);
		run_command(CMD_WRITE, 8'h00, 1'b1, 0, SDA_RANDOM);
		run_command(CMD_WAITACK, 8'h00, 1'b0, 3, SDA_RANDOM);
		run_command(CMD_READ, 8'hFF, 1'b0, 0, SDA_LOW);
		run_command(CMD_READ, 8'h5A, 1'b1, 0, SDA_RANDOM);
		run_command(CMD_WAITACK, 8'h00, 1'b0, NO_ACK, SDA_HIGH);
		run_command(CMD_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);
		settle();
	endtask

	task automatic extreme_sequence();
		run_command(CMD_START, 8'h00, 1'b0, 0, SDA_RANDOM);
		run_command(CMD_WRITE, 8'($urandom()), 1'b0, 0, SDA_RANDOM);
		run_command(CMD_WAITACK, 8'h00, 1'b0, 1, SDA_RANDOM);
		run_command(CMD_READ, 8'h00, 1'($urandom()), 0, SDA_RANDOM);
		run_command(CMD_WAITACK, 8'h00, 1'b0, NO_ACK, SDA_HIGH);
		run_command(CMD_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);
		settle();
	endtask

	task automatic test_config_extremes();
		write_all_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		extreme_sequence();
		write_all_regs(8'd1, 8'd1, 8'd1, 8'd1, 8'd255);
		extreme_sequence();
	endtask

	task automatic test_result_backpressure();
		item_t it;
		int    i;
		write_all_regs(8'd2, 8'd2, 8'd3, 8'd2, 8'd4);
		gaps_on = 0;
		hold_req = 250;
		for (i = 0; i < 60; i++) begin
			make_tick(it);
			send_tick(it);
		end
		run_command(CMD_IDLE, 8'h00, 1'b0, 0, SDA_RANDOM);
		gaps_on = 1;
		settle();
	endtask

	task automatic test_random_traffic();
		item_t it;
		int    round;
		int    i;
		for (round = 0; round < 4; round++) begin
			if (round == 0)
				write_all_regs(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
			else
				write_all_regs(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
					8'($urandom_range(1, 10)), 8'($urandom_range(1, 8)),
					8'($urandom_range(1, 15)));
			gaps_on = (round % 3 != 2);
			for (i = 0; i < 50; i++) begin
				make_tick(it);
				send_tick(it);
			end
			run_command(CMD_IDLE, 8'h00, 1'b0, 0, SDA_RANDOM);
			settle();
		end
		gaps_on = 1;
	endtask

	initial begin
		fail_count = 0;
		hold_req = 0;
		gaps_on = 1;
		last_issued = CMD_IDLE;
		reset_bus_model();
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		action     <= CMD_IDLE;
		write_data <= 8'd0;
		send_ack   <= 1'b0;
		sda_sample <= 1'b1;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= 32'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_commands();
		test_config_extremes();
		test_result_backpressure();
		test_random_traffic();

		settle();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_regs.sv
rtl/i2cm_step.sv
rtl/i2c_master_bit_engine.sv
rtl/i2cm_checker.sv
tb/tb_i2c_master_bit_engine.sv
